// ===== src/rlgr_pkg.sv =====
// ----------------------------------------------------------------------------
// rlgr_pkg
// Shared types, constants and helper functions for the RGB565 gradient
// recolour pipeline.
// ----------------------------------------------------------------------------
package rlgr_pkg;

    localparam int unsigned PIX_W   = 16;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STAGES  = 4;

    // Luminance weights, scaled by one thousand.
    localparam int unsigned LUMA_R = 299;
    localparam int unsigned LUMA_G = 587;
    localparam int unsigned LUMA_B = 114;
    localparam int unsigned SUM_W  = 18;

    // Division by 1000 as a reciprocal multiply, exact for sums below 2**18.
    localparam int unsigned DIV1000_SHIFT = 28;
    localparam int unsigned DIV1000_MUL   = 268436;
    localparam int unsigned DIV1000_MUL_W = 19;
    localparam int unsigned DIV1000_PROD_W = SUM_W + DIV1000_MUL_W;

    // Division by 255 as a reciprocal multiply, exact for values up to 255*255.
    localparam int unsigned ACC_W        = 16;
    localparam int unsigned DIV255_SHIFT = 24;
    localparam int unsigned DIV255_MUL   = 65794;
    localparam int unsigned DIV255_MUL_W = 17;
    localparam int unsigned DIV255_PROD_W = ACC_W + DIV255_MUL_W;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_KEY      = 2'd0,
        CFG_GRADIENT_START = 2'd1,
        CFG_GRADIENT_END   = 2'd2
    } t_cfg_idx;

    localparam logic [PIX_W-1:0] KEY_RESET   = 16'h0000;
    localparam logic [RGB_W-1:0] START_RESET = 24'h000000;
    localparam logic [RGB_W-1:0] END_RESET   = 24'hFFFFFF;

    // Load enables for the two register stages held by one module.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_pair_en;

    // Word passed from the luminance stages to the blend stages.
    typedef struct packed {
        logic             keyed;
        logic [PIX_W-1:0] pixel;
        logic [CH_W-1:0]  lum;
    } t_luma_word;

    function automatic logic [CH_W-1:0] expand5(input logic [4:0] v);
        expand5 = {v, v[4:2]};
    endfunction

    function automatic logic [CH_W-1:0] expand6(input logic [5:0] v);
        expand6 = {v, v[5:4]};
    endfunction

endpackage

// ===== src/rlgr_in_if.sv =====
// ----------------------------------------------------------------------------
// rlgr_in_if
// Valid/ready channel carrying one source pixel per word.
// ----------------------------------------------------------------------------
interface rlgr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== src/rlgr_out_if.sv =====
// ----------------------------------------------------------------------------
// rlgr_out_if
// Valid/ready channel carrying one recoloured pixel per word.
// ----------------------------------------------------------------------------
interface rlgr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== src/rlgr_luma.sv =====
// ----------------------------------------------------------------------------
// rlgr_luma
// Stages one and two: key compare, channel expansion, weighted sum and the
// division of that sum by one thousand.
// ----------------------------------------------------------------------------
module rlgr_luma
    import rlgr_pkg::*;
(
    input  logic             i_clk,
    input  t_pair_en         i_en,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [PIX_W-1:0] i_color_key,
    output t_luma_word       o_word
);

    logic [CH_W-1:0]           n_r8, n_g8, n_b8;
    logic [SUM_W-1:0]          n_s1_sum;
    logic                      n_s1_keyed;
    logic [DIV1000_PROD_W-1:0] n_prod;

    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s1_keyed;
    logic [PIX_W-1:0]  r_s1_pixel;
    t_luma_word        r_s2_word;

    always_comb begin
        n_r8 = expand5(i_pixel[15:11]);
        n_g8 = expand6(i_pixel[10:5]);
        n_b8 = expand5(i_pixel[4:0]);
        n_s1_sum = SUM_W'(LUMA_R) * SUM_W'(n_r8)
                 + SUM_W'(LUMA_G) * SUM_W'(n_g8)
                 + SUM_W'(LUMA_B) * SUM_W'(n_b8);
        n_s1_keyed = (i_pixel == i_color_key);
        n_prod = DIV1000_PROD_W'(r_s1_sum) * DIV1000_PROD_W'(DIV1000_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_s1_sum   <= n_s1_sum;
            r_s1_keyed <= n_s1_keyed;
            r_s1_pixel <= i_pixel;
        end
        if (i_en.load_b) begin
            r_s2_word.keyed <= r_s1_keyed;
            r_s2_word.pixel <= r_s1_pixel;
            r_s2_word.lum   <= n_prod[DIV1000_SHIFT +: CH_W];
        end
    end

    assign o_word = r_s2_word;

endmodule

// ===== src/rlgr_blend.sv =====
// ----------------------------------------------------------------------------
// rlgr_blend
// Stages three and four: per-channel gradient blend, division by 255 and
// packing back to RGB565, or passing a keyed pixel through.
// ----------------------------------------------------------------------------
module rlgr_blend
    import rlgr_pkg::*;
(
    input  logic             i_clk,
    input  t_pair_en         i_en,
    input  t_luma_word       i_word,
    input  logic [RGB_W-1:0] i_grad_start,
    input  logic [RGB_W-1:0] i_grad_end,
    output logic [PIX_W-1:0] o_pixel
);

    logic [CH_W-1:0]          n_inv;
    logic [2:0][ACC_W-1:0]    n_acc;
    logic [2:0][DIV255_PROD_W-1:0] n_prod;
    logic [2:0][CH_W-1:0]     n_ch;
    logic [PIX_W-1:0]         n_pixel;

    logic [2:0][ACC_W-1:0]    r_s3_acc;
    logic                     r_s3_keyed;
    logic [PIX_W-1:0]         r_s3_pixel;
    logic [PIX_W-1:0]         r_s4_pixel;

    // Channel 2 is red, 1 green and 0 blue, matching the packed colour layout.
    always_comb begin
        n_inv = CH_MAX - i_word.lum;
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = ACC_W'(i_grad_start[c*CH_W +: CH_W]) * ACC_W'(n_inv)
                     + ACC_W'(i_grad_end[c*CH_W +: CH_W]) * ACC_W'(i_word.lum);
            n_prod[c] = DIV255_PROD_W'(r_s3_acc[c]) * DIV255_PROD_W'(DIV255_MUL);
            n_ch[c]   = n_prod[c][DIV255_SHIFT +: CH_W];
        end
        n_pixel = r_s3_keyed ? r_s3_pixel
                             : {n_ch[2][7:3], n_ch[1][7:2], n_ch[0][7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_s3_acc   <= n_acc;
            r_s3_keyed <= i_word.keyed;
            r_s3_pixel <= i_word.pixel;
        end
        if (i_en.load_b) begin
            r_s4_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_s4_pixel;

endmodule

// ===== src/rgb565_luminance_gradient_recolor_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_luminance_gradient_recolor_core
// Recolours RGB565 pixels through a two-colour gradient indexed by luminance.
// ----------------------------------------------------------------------------
// Usage: source pixels arrive on i_pix and recoloured pixels leave on o_pix,
// both valid/ready channels moving one word per accepted handshake. A pixel
// equal to the colour key leaves unchanged; any other pixel is mapped by its
// luminance onto the gradient between the start and end colours.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata while the
// pipeline is empty; index 0 is the colour key, 1 the start colour and 2 the
// end colour. Other indices are ignored.
// A word accepted on i_pix passes through the four register stages in order:
// weighted sum, divide by one thousand, blend multiply, divide by 255 into
// the output register, from which it is offered on o_pix.
// Throughput is one pixel per cycle while o_pix is not stalled. Each stage holds its word when the one
// after it is full and stalled, so a stall on o_pix fills the empty stages
// first and only then drops i_pix.ready; nothing is lost or repeated.
// Reset clears all stage valid bits and returns the configuration to key
// 0x0000, start colour black and end colour white.
// ----------------------------------------------------------------------------
module rgb565_luminance_gradient_recolor_core
    import rlgr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    rlgr_in_if.sink              i_pix,
    rlgr_out_if.source           o_pix
);

    logic [PIX_W-1:0]  r_color_key;
    logic [RGB_W-1:0]  r_grad_start;
    logic [RGB_W-1:0]  r_grad_end;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;
    t_luma_word        w_luma;
    t_pair_en          w_luma_en;
    t_pair_en          w_blend_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_key  <= KEY_RESET;
            r_grad_start <= START_RESET;
            r_grad_end   <= END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_KEY:      r_color_key  <= i_cfg_wdata[PIX_W-1:0];
                CFG_GRADIENT_START: r_grad_start <= i_cfg_wdata[RGB_W-1:0];
                CFG_GRADIENT_END:   r_grad_end   <= i_cfg_wdata[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || o_pix.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_pix.valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_luma_en  = '{load_a: w_en[0], load_b: w_en[1]};
    assign w_blend_en = '{load_a: w_en[2], load_b: w_en[3]};

    rlgr_luma u_luma (
        .i_clk       (i_clk),
        .i_en        (w_luma_en),
        .i_pixel     (i_pix.pixel_in),
        .i_color_key (r_color_key),
        .o_word      (w_luma)
    );

    rlgr_blend u_blend (
        .i_clk        (i_clk),
        .i_en         (w_blend_en),
        .i_word       (w_luma),
        .i_grad_start (r_grad_start),
        .i_grad_end   (r_grad_end),
        .o_pixel      (o_pix.pixel_out)
    );

    assign i_pix.ready = w_en[0];
    assign o_pix.valid = r_vld[STAGES-1];

endmodule

// ===== src/rlgr_checker.sv =====
// ----------------------------------------------------------------------------
// rlgr_checker
// Port-level checks on the recolour pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rlgr_checker
    import rlgr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_pixel
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel))
        else $error("output word changed while stalled");

    // With the output register empty every stage can load.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled although the output is empty");

    // An accepted word reaches the output when the output stays ready while the word moves through the stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("accepted word did not reach the output in time");

endmodule

bind rgb565_luminance_gradient_recolor_core rlgr_checker u_rlgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out)
);
